FILE: src/manual_pulldown_field_planner_core_macros.svh
// Assertion macros for the pulldown field planner.
// Included by the controller and the datapath; expects clk_i and rst_ni in scope.
`ifndef MANUAL_PULLDOWN_FIELD_PLANNER_CORE_MACROS_SVH
`define MANUAL_PULLDOWN_FIELD_PLANNER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Clocked check, masked while reset is applied
`define MPFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Clocked check that also holds during reset
`define MPFP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define MPFP_ASSERT(lbl, prop, msg)
`define MPFP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: src/mpfp_pkg.sv
// Shared types and constants of the pulldown field planner.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package mpfp_pkg;

  localparam int unsigned MpfpMaxRanges = 2048;
  localparam int unsigned Group         = 5;
  localparam int unsigned PhaseLast     = 4;
  localparam int unsigned CfgW          = 12;

  typedef enum logic [0:0] {
    FUNC_LOAD  = 1'b0,
    FUNC_FRAME = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    CFG_INVERT      = 2'd0,
    CFG_TELECINE    = 2'd1,
    CFG_RANGE_COUNT = 2'd2
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_GO   = 5'b00010,
    ST_WAIT = 5'b00100,
    ST_PLAN = 5'b01000,
    ST_EMIT = 5'b10000
  } state_e;

  typedef struct packed {
    logic load_we;
    logic frame_start;
    logic srch_go;
    logic commit;
    logic plan;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic is_group;
    logic srch_done;
    logic srch_busy;
    logic last_search;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

FILE: src/mpfp_dp.sv
// Datapath of the pulldown field planner: range table, search engine, plan builder.
// Depends on mpfp_pkg and the assertion macro header; sequenced by mpfp_ctrl.
`default_nettype none
`include "manual_pulldown_field_planner_core_macros.svh"

module mpfp_dp import mpfp_pkg::*; #(
  parameter int unsigned MAX_RANGES = MpfpMaxRanges
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cmd_t               cmd_i,
  output sts_t                    sts_o,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_data_i,
  input  wire logic [31:0]        frame_number_i,
  input  wire logic [10:0]        entry_index_i,
  input  wire logic [31:0]        entry_start_i,
  input  wire logic [31:0]        entry_end_i,
  input  wire logic [2:0]         entry_cadence_i,
  input  wire logic               entry_flip_i,
  input  wire logic               out_stall_i,
  output logic                    out_valid_o,
  output logic signed [3:0]       top_source_o,
  output logic signed [3:0]       bottom_source_o,
  output logic                    group_start_o
);

  localparam int unsigned AW  = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int unsigned NW0 = $clog2(MAX_RANGES + 1);
  localparam int unsigned KW  = (NW0 > 12) ? NW0 : 12;
  localparam int unsigned EW  = 68;

  // remainder by five for values below ten
  function automatic logic [2:0] mod5_small(input logic [3:0] v);
    logic [3:0] r;
    r = (v >= 4'(Group)) ? v - 4'(Group) : v;
    return r[2:0];
  endfunction

  // configuration registers
  logic            inv_q, tel_q;
  logic [CfgW-1:0] rc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q <= 1'b0;
      tel_q <= 1'b0;
      rc_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_INVERT:      inv_q <= cfg_data_i[0];
        CFG_TELECINE:    tel_q <= cfg_data_i[0];
        CFG_RANGE_COUNT: rc_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective entry count
  logic [KW-1:0] n_w;
  assign n_w = (32'(rc_q) > MAX_RANGES) ? KW'(MAX_RANGES) : KW'(rc_q);

  // group detection: 16 = 1 mod 5, so nibble sums keep the remainder
  logic [6:0] nib_sum;
  logic [4:0] fold;
  logic [4:0] rem5;
  always_comb begin
    nib_sum = '0;
    for (int b = 0; b < 8; b++) begin
      nib_sum = nib_sum + 7'(frame_number_i[4*b +: 4]);
    end
    fold = 5'(nib_sum[6:4]) + 5'(nib_sum[3:0]);
    if (fold >= 5'd20)      rem5 = fold - 5'd20;
    else if (fold >= 5'd15) rem5 = fold - 5'd15;
    else if (fold >= 5'd10) rem5 = fold - 5'd10;
    else if (fold >= 5'd5)  rem5 = fold - 5'd5;
    else                    rem5 = fold;
  end

  // range table, one word per entry: start, end, cadence, flip
  logic [EW-1:0] range_mem [MAX_RANGES];
  logic [EW-1:0] rd_data_q;
  logic          slot_ok;
  assign slot_ok = 32'(entry_index_i) < MAX_RANGES;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we && slot_ok) begin
      range_mem[AW'(entry_index_i)] <= {entry_start_i, entry_end_i, entry_cadence_i, entry_flip_i};
    end
  end

  // search engine: one read per cycle, compared in the following cycle
  logic          running_q, done_q, rd_vld_q;
  logic [KW-1:0] addr_q, rd_idx_q, k_q;
  logic [2:0]    found_cad_q;
  logic          found_flip_q;
  logic [32:0]   img_q;
  logic          match_w, hit_w, done_w, issue_w;

  assign match_w = (img_q >= {1'b0, rd_data_q[67:36]}) && (img_q <= {1'b0, rd_data_q[35:4]});
  assign hit_w   = rd_vld_q && match_w;
  assign done_w  = running_q && (hit_w || (addr_q >= n_w));
  assign issue_w = running_q && !done_w && (addr_q < n_w);

  always_ff @(posedge clk_i) begin
    if (issue_w) begin
      rd_data_q <= range_mem[addr_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q    <= 1'b0;
      done_q       <= 1'b0;
      rd_vld_q     <= 1'b0;
      addr_q       <= '0;
      rd_idx_q     <= '0;
      k_q          <= '0;
      found_cad_q  <= '0;
      found_flip_q <= 1'b0;
    end else if (cmd_i.srch_go) begin
      running_q <= 1'b1;
      done_q    <= 1'b0;
      rd_vld_q  <= 1'b0;
      addr_q    <= '0;
    end else if (running_q) begin
      rd_vld_q <= issue_w;
      rd_idx_q <= addr_q;
      if (issue_w) addr_q <= addr_q + 1'b1;
      if (done_w) begin
        running_q <= 1'b0;
        done_q    <= 1'b1;
        k_q       <= hit_w ? rd_idx_q : n_w;
        if (hit_w) begin
          found_cad_q  <= rd_data_q[3:1];
          found_flip_q <= rd_data_q[0];
        end
      end
    end
  end

  // planner state
  logic [7:0]    plan_q [5];
  logic [2:0]    phase_q, sidx_q, lc_q, ec_q;
  logic [KW-1:0] prev_q;
  logic          cf_q, grp_q, rev4_q;
  logic [4:0]    pol_q, chg_q, comb_q;

  logic       found_w, new_cf_w;
  logic [2:0] new_lc_w;
  assign found_w  = k_q < n_w;
  assign new_lc_w = found_w ? found_cad_q : lc_q;
  assign new_cf_w = found_w ? (k_q != prev_q) : cf_q;

  // plan construction from the six search results
  logic [2:0] j0, nx, e1, drop;
  logic [4:0] comb_w;
  logic [7:0] pic [4];
  logic [7:0] plan_w [5];
  always_comb begin
    logic [2:0] j;
    j0 = 3'(Group);
    for (int i = 4; i >= 0; i--) begin
      if (chg_q[i]) j0 = 3'(i);
    end
    nx = mod5_small(4'(lc_q) + 4'd1);
    e1 = mod5_small(4'(ec_q) + 4'd1);
    if (!chg_q[0]) begin
      if (chg_q[e1])    drop = ec_q;
      else if (e1 < j0) drop = e1;
      else              drop = (nx >= j0) ? nx : lc_q;
    end else begin
      drop = nx;
    end
    comb_w = comb_q;
    if ((j0 > 3'd0) && (j0 < 3'(Group)) && (nx >= j0)) comb_w[nx] = 1'b1;

    j = '0;
    for (int i = 0; i < 4; i++) begin
      if (j == drop) j = j + 3'd1;
      if (j > 3'(PhaseLast)) j = 3'(PhaseLast);
      if (comb_w[j]) begin
        if (pol_q[j]) begin
          if (rev4_q && (j == 3'(PhaseLast))) pic[i] = {4'(j - 3'd1), 4'(j)};
          else                                pic[i] = {4'(j), 4'(j) + 4'd1};
        end else begin
          if (rev4_q && (j == 3'(PhaseLast))) pic[i] = {4'(j), 4'(j - 3'd1)};
          else                                pic[i] = {4'(j) + 4'd1, 4'(j)};
        end
      end else begin
        pic[i] = {4'(j), 4'(j)};
      end
      j = j + 3'd1;
    end

    plan_w[0] = pic[0];
    plan_w[1] = pic[1];
    plan_w[4] = pic[3];
    if (!tel_q) begin
      plan_w[2] = pic[2];
      plan_w[3] = pic[2];
    end else begin
      plan_w[2] = {pic[1][7:4], pic[2][3:0]};
      plan_w[3] = {pic[2][7:4], pic[3][3:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 5; i++) plan_q[i] <= '0;
      phase_q <= '0;
      sidx_q  <= '0;
      prev_q  <= KW'(12'hFFF);
      lc_q    <= 3'd2;
      ec_q    <= 3'd2;
      cf_q    <= 1'b0;
      grp_q   <= 1'b0;
      rev4_q  <= 1'b0;
      img_q   <= '0;
    end else begin
      if (cmd_i.frame_start) begin
        img_q  <= {1'b0, frame_number_i};
        grp_q  <= (rem5 == 5'd0);
        cf_q   <= 1'b0;
        sidx_q <= '0;
      end
      if (cmd_i.commit) begin
        if (sidx_q < 3'(Group)) begin
          if (found_w) begin
            lc_q <= found_cad_q;
            if (img_q == 33'd0) ec_q <= found_cad_q;
            if (k_q != prev_q) prev_q <= k_q;
          end
          cf_q   <= new_cf_w;
          img_q  <= img_q + 33'd1;
          sidx_q <= sidx_q + 3'd1;
        end else begin
          rev4_q <= (k_q != prev_q);
        end
      end
      if (cmd_i.plan) begin
        for (int i = 0; i < 5; i++) plan_q[i] <= plan_w[i];
        phase_q <= '0;
        ec_q    <= lc_q;
      end
      if (cmd_i.emit && (phase_q < 3'(PhaseLast))) phase_q <= phase_q + 3'd1;
    end
  end

  // per-search flags, indexed by search number
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && (sidx_q < 3'(Group))) begin
      pol_q[sidx_q]  <= found_w ? (found_flip_q ^ inv_q) : inv_q;
      chg_q[sidx_q]  <= new_cf_w;
      comb_q[sidx_q] <= (sidx_q == new_lc_w);
    end
  end

  // result register
  logic       out_valid_q, grp_out_q;
  logic [3:0] top_q, bot_q;
  logic [7:0] sel_w;
  assign sel_w = plan_q[phase_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      top_q     <= sel_w[7:4] - {1'b0, phase_q};
      bot_q     <= sel_w[3:0] - {1'b0, phase_q};
      grp_out_q <= grp_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign top_source_o    = signed'(top_q);
  assign bottom_source_o = signed'(bot_q);
  assign group_start_o   = grp_out_q;

  assign sts_o.is_group    = (rem5 == 5'd0);
  assign sts_o.srch_done   = done_q;
  assign sts_o.srch_busy   = running_q;
  assign sts_o.last_search = (sidx_q == 3'(Group));
  assign sts_o.out_free    = !out_valid_q || !out_stall_i;

  `MPFP_ASSERT_ALWAYS(a_phase_range, phase_q <= 3'(PhaseLast), "plan phase beyond last entry")
  `MPFP_ASSERT_ALWAYS(a_sidx_range, sidx_q <= 3'(Group), "search count beyond six")
  `MPFP_ASSERT(a_emit_valid, cmd_i.emit |=> out_valid_q, "emitted result not presented")

endmodule

`default_nettype wire

FILE: src/mpfp_ctrl.sv
// Controller of the pulldown field planner: sequences loads, searches and output.
// Depends on mpfp_pkg and the assertion macro header; drives mpfp_dp by commands.
`default_nettype none
`include "manual_pulldown_field_planner_core_macros.svh"

module mpfp_ctrl import mpfp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire logic func_i,
  output logic      in_stall_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (func_e'(func_i) == FUNC_LOAD) begin
            cmd_o.load_we = 1'b1;
          end else begin
            cmd_o.frame_start = 1'b1;
            state_d = sts_i.is_group ? ST_GO : ST_EMIT;
          end
        end
      end
      ST_GO: begin
        cmd_o.srch_go = 1'b1;
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (sts_i.srch_done) begin
          cmd_o.commit = 1'b1;
          state_d = sts_i.last_search ? ST_PLAN : ST_GO;
        end
      end
      ST_PLAN: begin
        cmd_o.plan = 1'b1;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  `MPFP_ASSERT(a_frame_leaves_idle,
    (state_q == ST_IDLE && in_valid_i && func_i == FUNC_FRAME) |=> (state_q != ST_IDLE),
    "accepted frame not processed")
  `MPFP_ASSERT(a_emit_returns, (state_q == ST_EMIT && sts_i.out_free) |=> (state_q == ST_IDLE),
    "emit did not return to idle")
  `MPFP_ASSERT(a_go_not_busy, (state_q == ST_GO) |-> !sts_i.srch_busy,
    "search started while one is running")

endmodule

`default_nettype wire

FILE: src/manual_pulldown_field_planner_core.sv
// Manual 3:2 pulldown field planner, top level.
// Depends on mpfp_pkg, mpfp_ctrl and mpfp_dp.
//
// A load item writes one range table entry. A frame item whose number is not a multiple of
// five goes straight to emitting its result. A group frame runs six table searches through
// the single read port of the range table, one entry per cycle, each over at most the n
// entries of the effective range count, then builds the plan and emits the result. Results
// leave through an output register, so a finished result may wait while the next item is taken.
`default_nettype none

module manual_pulldown_field_planner_core import mpfp_pkg::*; #(
  parameter int unsigned MAX_RANGES = MpfpMaxRanges
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_idx_i,
  input  wire logic [CfgW-1:0]   cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              func_i,
  input  wire logic [31:0]       frame_number_i,
  input  wire logic [10:0]       entry_index_i,
  input  wire logic [31:0]       entry_start_i,
  input  wire logic [31:0]       entry_end_i,
  input  wire logic [2:0]        entry_cadence_i,
  input  wire logic              entry_flip_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic signed [3:0]      top_source_o,
  output logic signed [3:0]      bottom_source_o,
  output logic                   group_start_o
);

  cmd_t cmd;
  sts_t sts;

  mpfp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mpfp_dp #(
    .MAX_RANGES (MAX_RANGES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .frame_number_i  (frame_number_i),
    .entry_index_i   (entry_index_i),
    .entry_start_i   (entry_start_i),
    .entry_end_i     (entry_end_i),
    .entry_cadence_i (entry_cadence_i),
    .entry_flip_i    (entry_flip_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .top_source_o    (top_source_o),
    .bottom_source_o (bottom_source_o),
    .group_start_o   (group_start_o)
  );

endmodule

`default_nettype wire
